@@ rtl/ppp_pkg.sv @@
// path payload parser package: result record, step bundle, item kinds and constants
// used by ppp_core and path_payload_parser; depends on nothing else
package ppp_pkg;

  localparam int FRAME_LENGTH_W = 21;

  // item kinds
  localparam logic [2:0] KIND_META     = 3'd0;
  localparam logic [2:0] KIND_POINT    = 3'd1;
  localparam logic [2:0] KIND_COMPLETE = 3'd2;
  localparam logic [2:0] KIND_DROPPED  = 3'd3;
  localparam logic [2:0] KIND_FRAME_END = 3'd4;

  // configuration register indexes
  localparam logic REG_FORMAT_U16 = 1'b0;
  localparam logic REG_FORMAT_F32 = 1'b1;

  // block sizes in bytes
  localparam int META_ENTRY_BYTES = 12;
  localparam int U16_POINT_BYTES  = 10;
  localparam int F32_POINT_BYTES  = 11;
  localparam int KEY_BYTES        = 8;

  localparam int MAX_RESULTS = 3;

  typedef struct packed {
    logic [2:0]  item_kind;
    logic [7:0]  path_format;
    logic [63:0] meta_key;
    logic [3:0]  key_length;
    logic [31:0] meta_value;
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [15:0] color_r;
    logic [15:0] color_g;
    logic [15:0] color_b;
    logic        last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0]                    count;
    result_t [MAX_RESULTS-1:0]     slot;
  } step_t;

  // blank result of a given kind
  function automatic result_t make_result(input logic [2:0] kind, input logic [7:0] fmt);
    result_t r;
    r = '0;
    r.item_kind   = kind;
    r.path_format = fmt;
    return r;
  endfunction

endpackage

@@ rtl/ppp_core.sv @@
// path payload parser core: frame tracking, path parse state and format registers
// works out every result of one byte in a single pass; uses ppp_pkg
module ppp_core #(
  parameter int MAX_FRAME_BYTES = 1048576
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic [7:0]                        data_byte,
  input  logic                              frame_start,
  input  logic [ppp_pkg::FRAME_LENGTH_W-1:0] frame_length,
  input  logic                              cfg_write,
  input  logic                              cfg_index,
  input  logic [7:0]                        cfg_data,
  output ppp_pkg::step_t                    step
);
  import ppp_pkg::*;

  localparam int FW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int LW = (FW > FRAME_LENGTH_W) ? FW : FRAME_LENGTH_W;
  localparam int CW = (FW > 20) ? FW : 20;

  typedef enum logic [2:0] {
    PH_FORMAT  = 3'd0,
    PH_MCOUNT  = 3'd1,
    PH_META    = 3'd2,
    PH_CNT_LO  = 3'd3,
    PH_CNT_HI  = 3'd4,
    PH_POINTS  = 3'd5
  } phase_t;

  logic [7:0]    format_code_u16;
  logic [7:0]    format_code_f32;

  logic [FW-1:0] byte_offset, byte_offset_next;
  logic [FW-1:0] frame_size, frame_size_next;
  phase_t        phase, phase_next;
  logic [7:0]    current_format, current_format_next;
  logic [7:0]    meta_left, meta_left_next;
  logic [3:0]    field_byte, field_byte_next;
  logic [63:0]   key_shift, key_shift_next;
  logic [31:0]   value_shift, value_shift_next;
  logic [7:0]    count_low_byte, count_low_byte_next;
  logic [15:0]   points_left, points_left_next;
  logic [31:0]   coord_x_shift, coord_x_shift_next;
  logic [31:0]   coord_y_shift, coord_y_shift_next;
  logic [15:0]   red_shift, red_shift_next;
  logic [15:0]   green_shift, green_shift_next;
  logic          skip_rest, skip_rest_next;

  // one byte: frame handling, path parse, frame end
  always_comb begin
    logic [1:0]    n;
    result_t       r;
    logic [FW-1:0] pos;
    logic [FW-1:0] rem;
    logic [LW-1:0] len_ext;
    logic [FW-1:0] len_sat;
    logic [CW-1:0] rem_ext;
    logic [CW-1:0] need;
    logic [3:0]    fb;
    logic [3:0]    kl;
    logic [15:0]   pc;
    logic [15:0]   bl;
    logic          wide;
    logic          narrow;
    logic          done;

    byte_offset_next    = byte_offset;
    frame_size_next     = frame_size;
    phase_next          = phase;
    current_format_next = current_format;
    meta_left_next      = meta_left;
    field_byte_next     = field_byte;
    key_shift_next      = key_shift;
    value_shift_next    = value_shift;
    count_low_byte_next = count_low_byte;
    points_left_next    = points_left;
    coord_x_shift_next  = coord_x_shift;
    coord_y_shift_next  = coord_y_shift;
    red_shift_next      = red_shift;
    green_shift_next    = green_shift;
    skip_rest_next      = skip_rest;

    n       = '0;
    step    = '0;
    r       = '0;
    pos     = '0;
    rem     = '0;
    rem_ext = '0;
    need    = '0;
    fb      = '0;
    kl      = '0;
    pc      = '0;
    bl      = '0;
    wide    = 1'b0;
    narrow  = 1'b0;
    done    = 1'b0;

    // new frame: abandon any open path, saturate the length
    len_ext = LW'(frame_length);
    if (len_ext > LW'(MAX_FRAME_BYTES)) len_sat = FW'(MAX_FRAME_BYTES);
    else len_sat = FW'(frame_length);

    if (frame_start) begin
      if (byte_offset < frame_size && !skip_rest && phase != PH_FORMAT) begin
        step.slot[n] = make_result(KIND_DROPPED, current_format);
        n = n + 2'd1;
      end
      frame_size_next  = len_sat;
      byte_offset_next = '0;
      phase_next       = PH_FORMAT;
      skip_rest_next   = 1'b0;
      field_byte_next  = '0;
      if (len_sat == '0) begin
        step.slot[n] = make_result(KIND_FRAME_END, 8'd0);
        n = n + 2'd1;
      end
    end

    if (byte_offset_next < frame_size_next) begin
      pos     = byte_offset_next + FW'(1);
      rem     = frame_size_next - pos;
      rem_ext = CW'(rem);
      fb      = field_byte_next;

      if (!skip_rest_next) begin
        case (phase_next)
          PH_FORMAT: begin
            current_format_next = data_byte;
            if (rem == '0) begin
              step.slot[n] = make_result(KIND_DROPPED, data_byte);
              n = n + 2'd1;
              skip_rest_next = 1'b1;
              phase_next     = PH_FORMAT;
            end else begin
              phase_next = PH_MCOUNT;
            end
          end

          PH_MCOUNT: begin
            meta_left_next  = data_byte;
            field_byte_next = '0;
            need = CW'(data_byte) * CW'(META_ENTRY_BYTES);
            if (rem_ext < need || (data_byte == 8'd0 && rem_ext < CW'(2))) begin
              step.slot[n] = make_result(KIND_DROPPED, current_format_next);
              n = n + 2'd1;
              skip_rest_next = 1'b1;
              phase_next     = PH_FORMAT;
            end else if (data_byte != 8'd0) begin
              phase_next = PH_META;
            end else begin
              phase_next = PH_CNT_LO;
            end
          end

          PH_META: begin
            // key bytes then value bytes, both little-endian
            if (fb < 4'(KEY_BYTES)) key_shift_next[8*fb[2:0] +: 8] = data_byte;
            else value_shift_next[8*fb[1:0] +: 8] = data_byte;

            if (fb >= 4'(META_ENTRY_BYTES - 1)) begin
              // trim trailing zero key bytes
              for (int i = 0; i < KEY_BYTES; i++) begin
                if (key_shift_next[8*i +: 8] != 8'd0) kl = 4'(i + 1);
              end
              r = make_result(KIND_META, current_format_next);
              r.meta_key   = key_shift_next;
              r.key_length = kl;
              r.meta_value = value_shift_next;
              step.slot[n] = r;
              n = n + 2'd1;
              field_byte_next = '0;
              meta_left_next  = meta_left_next - 8'd1;
              if (meta_left_next == 8'd0) begin
                if (rem_ext < CW'(2)) begin
                  step.slot[n] = make_result(KIND_DROPPED, current_format_next);
                  n = n + 2'd1;
                  skip_rest_next = 1'b1;
                  phase_next     = PH_FORMAT;
                end else begin
                  phase_next = PH_CNT_LO;
                end
              end
            end else begin
              field_byte_next = fb + 4'd1;
            end
          end

          PH_CNT_LO: begin
            count_low_byte_next = data_byte;
            phase_next          = PH_CNT_HI;
          end

          PH_CNT_HI: begin
            pc     = {data_byte, count_low_byte_next};
            wide   = (current_format_next == format_code_u16);
            narrow = (current_format_next == format_code_f32);
            if (wide) need = CW'(pc) * CW'(U16_POINT_BYTES);
            else need = CW'(pc) * CW'(F32_POINT_BYTES);
            if ((!wide && !narrow) || rem_ext < need) begin
              step.slot[n] = make_result(KIND_DROPPED, current_format_next);
              n = n + 2'd1;
              skip_rest_next = 1'b1;
              phase_next     = PH_FORMAT;
            end else if (pc == 16'd0) begin
              step.slot[n] = make_result(KIND_COMPLETE, current_format_next);
              n = n + 2'd1;
              phase_next = PH_FORMAT;
            end else begin
              points_left_next = pc;
              field_byte_next  = '0;
              phase_next       = PH_POINTS;
            end
          end

          PH_POINTS: begin
            wide = (current_format_next == format_code_u16);
            if (wide) begin
              // five 16-bit codes, low byte first
              case (fb[3:1])
                3'd0: coord_x_shift_next = fb[0] ?
                        {16'd0, data_byte, coord_x_shift_next[7:0]} : {24'd0, data_byte};
                3'd1: coord_y_shift_next = fb[0] ?
                        {16'd0, data_byte, coord_y_shift_next[7:0]} : {24'd0, data_byte};
                3'd2: red_shift_next = fb[0] ?
                        {data_byte, red_shift_next[7:0]} : {8'd0, data_byte};
                3'd3: green_shift_next = fb[0] ?
                        {data_byte, green_shift_next[7:0]} : {8'd0, data_byte};
                default: begin
                  if (!fb[0]) begin
                    count_low_byte_next = data_byte;
                  end else begin
                    bl   = {data_byte, count_low_byte_next};
                    done = 1'b1;
                  end
                end
              endcase
            end else begin
              // two float words then three colour bytes
              if (fb < 4'd4) begin
                if (fb == 4'd0) coord_x_shift_next = '0;
                coord_x_shift_next[8*fb[1:0] +: 8] = data_byte;
              end else if (fb < 4'd8) begin
                if (fb == 4'd4) coord_y_shift_next = '0;
                coord_y_shift_next[8*fb[1:0] +: 8] = data_byte;
              end else if (fb == 4'd8) begin
                red_shift_next = {8'd0, data_byte};
              end else if (fb == 4'd9) begin
                green_shift_next = {8'd0, data_byte};
              end else begin
                bl   = {8'd0, data_byte};
                done = 1'b1;
              end
            end

            if (done) begin
              r = make_result(KIND_POINT, current_format_next);
              r.point_x = coord_x_shift_next;
              r.point_y = coord_y_shift_next;
              r.color_r = red_shift_next;
              r.color_g = green_shift_next;
              r.color_b = bl;
              step.slot[n] = r;
              n = n + 2'd1;
              field_byte_next  = '0;
              points_left_next = points_left_next - 16'd1;
              if (points_left_next == 16'd0) begin
                step.slot[n] = make_result(KIND_COMPLETE, current_format_next);
                n = n + 2'd1;
                phase_next = PH_FORMAT;
              end
            end else begin
              field_byte_next = fb + 4'd1;
            end
          end

          default: phase_next = PH_FORMAT;
        endcase
      end

      byte_offset_next = pos;
      if (pos == frame_size_next) begin
        step.slot[n] = make_result(KIND_FRAME_END, 8'd0);
        n = n + 2'd1;
      end
    end

    // mark the final result of this byte
    if (n != 2'd0) step.slot[n - 2'd1].last_of_run = 1'b1;
    step.count = n;
  end

  // state and format registers
  always_ff @(posedge clk) begin
    if (rst) begin
      format_code_u16 <= 8'd0;
      format_code_f32 <= 8'd1;
      byte_offset     <= '0;
      frame_size      <= '0;
      phase           <= PH_FORMAT;
      current_format  <= '0;
      meta_left       <= '0;
      field_byte      <= '0;
      points_left     <= '0;
      skip_rest       <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_FORMAT_U16: format_code_u16 <= cfg_data;
          REG_FORMAT_F32: format_code_f32 <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        byte_offset    <= byte_offset_next;
        frame_size     <= frame_size_next;
        phase          <= phase_next;
        current_format <= current_format_next;
        meta_left      <= meta_left_next;
        field_byte     <= field_byte_next;
        points_left    <= points_left_next;
        skip_rest      <= skip_rest_next;
      end
    end
  end

  // field assembly registers
  always_ff @(posedge clk) begin
    if (accept) begin
      key_shift      <= key_shift_next;
      value_shift    <= value_shift_next;
      count_low_byte <= count_low_byte_next;
      coord_x_shift  <= coord_x_shift_next;
      coord_y_shift  <= coord_y_shift_next;
      red_shift      <= red_shift_next;
      green_shift    <= green_shift_next;
    end
  end

endmodule

@@ rtl/path_payload_parser.sv @@
// path payload parser top level: input handshake, result queue and output port
// uses ppp_pkg and ppp_core
//
//   channel  direction  handshake                      payload
//   input    in         in_valid / in_ready            data_byte, frame_start, frame_length
//   output   out        out_valid / out_ready          item_kind .. last_of_run
//   config   in         cfg_write (no wait)            cfg_index, cfg_data
//
// each byte is parsed in the cycle it is accepted and its zero to three results land
// in a three-deep result queue; the queue drains one result a cycle while out_ready is high
// a byte with at most one result sustains one byte a cycle while out_ready is high; a
// byte with more results holds the input while the queue drains to its last result
// a stalled output holds the input back while any result waits in the queue
// synchronous reset clears the frame state, the queue and sets the format codes to 0 and 1
module path_payload_parser #(
  parameter int MAX_FRAME_BYTES = 1048576
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         data_byte,
  input  logic                               frame_start,
  input  logic [ppp_pkg::FRAME_LENGTH_W-1:0] frame_length,
  input  logic                               cfg_write,
  input  logic                               cfg_index,
  input  logic [7:0]                         cfg_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [2:0]                         item_kind,
  output logic [7:0]                         path_format,
  output logic [63:0]                        meta_key,
  output logic [3:0]                         key_length,
  output logic [31:0]                        meta_value,
  output logic [31:0]                        point_x,
  output logic [31:0]                        point_y,
  output logic [15:0]                        color_r,
  output logic [15:0]                        color_g,
  output logic [15:0]                        color_b,
  output logic                               last_of_run
);
  import ppp_pkg::*;

  step_t                     step;
  result_t [MAX_RESULTS-1:0] queue;
  logic [1:0]                queue_count;
  logic                      accept;
  logic                      pop;

  // take a byte when the queue is empty or about to be
  assign out_valid = (queue_count != 2'd0);
  assign pop       = out_valid && out_ready;
  assign in_ready  = (queue_count == 2'd0) || (queue_count == 2'd1 && out_ready);
  assign accept    = in_valid && in_ready;

  ppp_core #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (data_byte),
    .frame_start  (frame_start),
    .frame_length (frame_length),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .step         (step)
  );

  // result queue: load on accept, shift down on pop
  always_ff @(posedge clk) begin
    if (rst) begin
      queue_count <= 2'd0;
    end else if (accept) begin
      queue_count <= step.count;
    end else if (pop) begin
      queue_count <= queue_count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      queue <= step.slot;
    end else if (pop) begin
      queue[0] <= queue[1];
      queue[1] <= queue[2];
    end
  end

  // head of queue drives the output item
  assign item_kind   = queue[0].item_kind;
  assign path_format = queue[0].path_format;
  assign meta_key    = queue[0].meta_key;
  assign key_length  = queue[0].key_length;
  assign meta_value  = queue[0].meta_value;
  assign point_x     = queue[0].point_x;
  assign point_y     = queue[0].point_y;
  assign color_r     = queue[0].color_r;
  assign color_g     = queue[0].color_g;
  assign color_b     = queue[0].color_b;
  assign last_of_run = queue[0].last_of_run;

endmodule
